FILE: hw/rtl/antp_pkg.sv
// ----------------------------------------------------------------------------
// antp_pkg
// Types, tables and constants shared by the antenna noise temperature blocks.
// ----------------------------------------------------------------------------
package antp_pkg;

   localparam int NPTS    = 26;
   localparam int NSRC    = 5;
   localparam int SEG_W   = 5;
   localparam int FREQ_W  = 17;
   localparam int SPAN_W  = 14;
   localparam int TAB_W   = 33;
   localparam int PROD_W  = 37;
   localparam int DIV_W   = PROD_W + 1;
   localparam int BASE_W  = 20;
   localparam int TOT_W   = 30;
   localparam int SUM_W   = DIV_W + 3;
   localparam int TAB_FRAC = 8;

   localparam logic [TOT_W-1:0] TOTAL_MAX = '1;

   // source order in the enable vector
   localparam int SRC_MAN = 0;
   localparam int SRC_GAL = 1;
   localparam int SRC_SUN = 2;
   localparam int SRC_SKY = 3;
   localparam int SRC_COS = 4;

   localparam logic [FREQ_W-1:0] FREQ_MHZ [NPTS] = '{
      17'd10, 17'd20, 17'd50, 17'd80, 17'd100, 17'd200, 17'd500, 17'd900,
      17'd1000, 17'd1400, 17'd2000, 17'd2800, 17'd5000, 17'd6200, 17'd10000,
      17'd16000, 17'd20000, 17'd24000, 17'd30000, 17'd40000, 17'd50000,
      17'd60000, 17'd70000, 17'd80000, 17'd90000, 17'd100000};

   // noise temperatures, kelvin * 2^8
   localparam logic [TAB_W-1:0] NOISE_TAB [NSRC][NPTS] = '{
      '{33'd7424000000, 33'd1481282743, 33'd148128274, 33'd37208140,
        33'd11766247, 33'd2634135, 33'd832987, 33'd468423,
        33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0,
        33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0},
      '{33'd93462623, 33'd18648245, 33'd2955548, 33'd934626, 33'd832987,
        33'd186482, 33'd23477, 33'd5897, 33'd4684, 33'd2634, 33'd1481,
        33'd1177, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0,
        33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0},
      '{33'd0, 33'd0, 33'd0, 33'd0, 33'd186482449, 33'd132019463,
        33'd58970928, 33'd41748220, 33'd33161790, 33'd23476749,
        33'd16620266, 33'd11766247, 33'd5255790, 33'd4174822, 33'd2955548,
        33'd2092367, 33'd1864824, 33'd1662027, 33'd1481283, 33'd1320195,
        33'd1176625, 33'd1176625, 33'd1176625, 33'd1176625, 33'd1176625,
        33'd1176625},
      '{33'd1176624706, 33'd4684227, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0,
        33'd14813, 33'd16620, 33'd18648, 33'd20924, 33'd26341, 33'd29555,
        33'd33162, 33'd37208, 33'd46842, 33'd58971, 33'd74240, 33'd74240,
        33'd74240, 33'd74240, 33'd74240, 33'd74240, 33'd74240, 33'd74240,
        33'd74240},
      '{33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0,
        33'd691, 33'd691, 33'd691, 33'd691, 33'd691, 33'd691, 33'd691,
        33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0, 33'd0,
        33'd0}};

   typedef struct packed {
      logic [FREQ_W-1:0] carrier_mhz;
      logic              man_made_on;
      logic              galactic_on;
      logic              sun_on;
      logic              sky_on;
      logic              cosmic_on;
   } req_type;

   typedef struct packed {
      logic [TOT_W-1:0] total_temp;
      logic             out_of_range;
   } rsp_type;

   // front -> back: partial products per source
   typedef struct packed {
      logic [NSRC-1:0][PROD_W-1:0] p1;
      logic [NSRC-1:0][PROD_W-1:0] p2;
      logic [NSRC-1:0]             dec;
      logic [SPAN_W-1:0]           span;
      logic                        oor;
   } mid_type;

endpackage

FILE: hw/rtl/antenna_noise_temp_interp.sv
// ----------------------------------------------------------------------------
// antenna_noise_temp_interp
// Antenna noise temperature from piecewise linear noise tables.
// ----------------------------------------------------------------------------
// Usage:
//  - Requests enter as a queue: drive req_data and req_push; a beat is taken
//    when req_push is high and req_full is low. One beat per cycle unless full.
//  - Results leave as a queue: rsp_data holds the oldest result while
//    rsp_empty is low; rsp_pop takes it. Results come out in request order.
//  - csr_we/csr_wdata write the base temperature (kelvin * 2^FRAC_BITS);
//    write only while no request is in flight.
//  - Path: two front stages (segment search, table products), a two-entry
//    queue, one rounding stage, 19 divider stages at two quotient bits each,
//    a summing stage and the result FIFO.
//  - Throughput is one request per cycle unless back-pressured, set by the fully
//    pipelined divider; the 32-entry result FIFO covers the back-end latency.
//  - When the receiver stalls, the back end stops issuing once its
//    outstanding count reaches the FIFO depth, the mid queue fills, and
//    req_full rises. Nothing is dropped.
//  - Reset empties all queues and clears the base temperature to zero.
// ----------------------------------------------------------------------------
module antenna_noise_temp_interp #(
   parameter int FRAC_BITS = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_push,
   input  antp_pkg::req_type           req_data,
   output logic                        req_full,
   output logic                        rsp_empty,
   input  logic                        rsp_pop,
   output antp_pkg::rsp_type           rsp_data,
   input  logic                        csr_we,
   input  logic [antp_pkg::BASE_W-1:0] csr_wdata
);
   localparam int OUT_DEPTH = 32;
   localparam int MID_W = $bits(antp_pkg::mid_type);
   localparam int RSP_W = $bits(antp_pkg::rsp_type);

   logic [antp_pkg::BASE_W-1:0] base_temp_ff, base_temp_in;
   logic              front_rdy;
   logic              mid_push, mid_full, mid_empty, mid_pop;
   antp_pkg::mid_type mid_wdata, mid_rdata;
   logic [MID_W-1:0]  mid_rbits;
   logic              back_vld;
   antp_pkg::rsp_type back_data;
   logic [RSP_W-1:0]  rsp_bits;
   logic              out_full;
   logic              rsp_take;

   assign base_temp_in = csr_we ? csr_wdata : base_temp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_temp_ff <= '0;
      end else begin
         base_temp_ff <= base_temp_in;
      end
   end

   assign req_full  = !front_rdy;
   assign mid_rdata = antp_pkg::mid_type'(mid_rbits);
   assign rsp_data  = antp_pkg::rsp_type'(rsp_bits);
   assign rsp_take  = rsp_pop && !rsp_empty;

   antp_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_vld   (req_push),
      .in_data  (req_data),
      .in_rdy   (front_rdy),
      .out_vld  (mid_push),
      .out_data (mid_wdata),
      .out_full (mid_full)
   );

   antp_queue #(.WIDTH(MID_W), .DEPTH(2)) u_mid_q (
      .clock (clock),
      .reset (reset),
      .push  (mid_push),
      .wdata (mid_wdata),
      .full  (mid_full),
      .pop   (mid_pop),
      .rdata (mid_rbits),
      .empty (mid_empty)
   );

   antp_back #(.FRAC_BITS(FRAC_BITS), .OUT_DEPTH(OUT_DEPTH)) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_avail  (!mid_empty),
      .in_data   (mid_rdata),
      .in_take   (mid_pop),
      .base_temp (base_temp_ff),
      .out_pop   (rsp_take),
      .out_vld   (back_vld),
      .out_data  (back_data)
   );

   // never overflows: back end holds a credit per entry
   antp_queue #(.WIDTH(RSP_W), .DEPTH(OUT_DEPTH)) u_out_q (
      .clock (clock),
      .reset (reset),
      .push  (back_vld && !out_full),
      .wdata (back_data),
      .full  (out_full),
      .pop   (rsp_pop),
      .rdata (rsp_bits),
      .empty (rsp_empty)
   );

endmodule

FILE: hw/rtl/antp_queue.sv
// ----------------------------------------------------------------------------
// antp_queue
// Small flop-based FIFO, first word visible while not empty.
// ----------------------------------------------------------------------------
module antp_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);
   localparam int AW = $clog2(DEPTH);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [AW:0]      cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == (AW+1)'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rptr_ff];

   always_comb begin
      wptr_in = do_push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = do_pop ? rptr_ff + 1'b1 : rptr_ff;
      cnt_in  = cnt_ff + (AW+1)'(do_push) - (AW+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         cnt_ff  <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wptr_ff] <= wdata;
      end
   end

endmodule

FILE: hw/rtl/antp_front.sv
// ----------------------------------------------------------------------------
// antp_front
// Range check, segment search, table lookup and interpolation products.
// ----------------------------------------------------------------------------
module antp_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_vld,
   input  antp_pkg::req_type in_data,
   output logic              in_rdy,
   output logic              out_vld,
   output antp_pkg::mid_type out_data,
   input  logic              out_full
);
   localparam int NS = antp_pkg::NSRC;

   // stage 1: classify
   logic                              s1_vld_ff, s1_vld_in;
   logic [antp_pkg::FREQ_W-1:0]       s1_c_ff;
   logic [antp_pkg::SEG_W-1:0]        s1_seg_ff, seg_w;
   logic [NS-1:0]                     s1_en_ff, en_w;
   logic                              s1_oor_ff, oor_w, outside_w;
   // stage 2: products
   logic                              s2_vld_ff, s2_vld_in;
   antp_pkg::mid_type                 s2_ff, s2_w;
   logic                              adv1, adv2;

   assign adv2   = !s2_vld_ff || !out_full;
   assign adv1   = !s1_vld_ff || adv2;
   assign in_rdy = adv1;
   assign out_vld  = s2_vld_ff;
   assign out_data = s2_ff;

   always_comb begin
      en_w = {in_data.cosmic_on, in_data.sky_on, in_data.sun_on,
              in_data.galactic_on, in_data.man_made_on};
      outside_w = (in_data.carrier_mhz < antp_pkg::FREQ_MHZ[0]) ||
                  (in_data.carrier_mhz > antp_pkg::FREQ_MHZ[antp_pkg::NPTS-1]);
      oor_w = outside_w && (en_w != '0);
      seg_w = '0;
      for (int i = 0; i < antp_pkg::NPTS - 1; i++) begin
         if (antp_pkg::FREQ_MHZ[i] <= in_data.carrier_mhz) begin
            seg_w = antp_pkg::SEG_W'(i);
         end
      end
      if (outside_w) begin
         en_w  = '0;
         seg_w = '0;
      end
   end

   always_comb begin
      logic [antp_pkg::SEG_W-1:0]         seg_hi;
      logic [antp_pkg::FREQ_W-1:0]        f1, span17;
      logic [antp_pkg::SPAN_W-1:0]        span, off;
      logic [antp_pkg::TAB_W-1:0]         t1, t2, dt;
      logic [antp_pkg::TAB_W+antp_pkg::SPAN_W-1:0] m1, m2;
      seg_hi = s1_seg_ff + 1'b1;
      f1     = antp_pkg::FREQ_MHZ[s1_seg_ff];
      span17 = antp_pkg::FREQ_MHZ[seg_hi] - f1;
      span   = span17[antp_pkg::SPAN_W-1:0];
      off    = antp_pkg::SPAN_W'(s1_c_ff - f1);
      s2_w      = '0;
      s2_w.span = span;
      s2_w.oor  = s1_oor_ff;
      for (int s = 0; s < NS; s++) begin
         t1 = antp_pkg::NOISE_TAB[s][s1_seg_ff];
         t2 = antp_pkg::NOISE_TAB[s][seg_hi];
         dt = (t2 < t1) ? t1 - t2 : t2 - t1;
         m1 = {{antp_pkg::SPAN_W{1'b0}}, t1} * {{antp_pkg::TAB_W{1'b0}}, span};
         m2 = {{antp_pkg::SPAN_W{1'b0}}, dt} * {{antp_pkg::TAB_W{1'b0}}, off};
         // a source counts only with both segment ends nonzero
         if (s1_en_ff[s] && t1 != '0 && t2 != '0) begin
            s2_w.p1[s]  = m1[antp_pkg::PROD_W-1:0];
            s2_w.p2[s]  = m2[antp_pkg::PROD_W-1:0];
            s2_w.dec[s] = (t2 < t1);
         end
      end
   end

   always_comb begin
      s1_vld_in = adv1 ? in_vld : s1_vld_ff;
      s2_vld_in = adv2 ? s1_vld_ff : s2_vld_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
      end else begin
         s1_vld_ff <= s1_vld_in;
         s2_vld_ff <= s2_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv1) begin
         s1_c_ff   <= in_data.carrier_mhz;
         s1_seg_ff <= seg_w;
         s1_en_ff  <= en_w;
         s1_oor_ff <= oor_w;
      end
      if (adv2) begin
         s2_ff <= s2_w;
      end
   end

endmodule

FILE: hw/rtl/antp_back.sv
// ----------------------------------------------------------------------------
// antp_back
// Rounding, pipelined division by segment span, and summation.
// ----------------------------------------------------------------------------
module antp_back #(
   parameter int FRAC_BITS = 4,
   parameter int OUT_DEPTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_avail,
   input  antp_pkg::mid_type             in_data,
   output logic                          in_take,
   input  logic [antp_pkg::BASE_W-1:0]   base_temp,
   input  logic                          out_pop,
   output logic                          out_vld,
   output antp_pkg::rsp_type             out_data
);
   localparam int NS    = antp_pkg::NSRC;
   localparam int DW    = antp_pkg::DIV_W;
   localparam int SW    = antp_pkg::SPAN_W;
   localparam int K     = antp_pkg::TAB_FRAC - FRAC_BITS;
   localparam int NSTEP = DW / 2;
   localparam int HW    = SW + antp_pkg::TAB_FRAC + 1;
   localparam int CW    = $clog2(OUT_DEPTH) + 1;

   logic [CW-1:0]               credit_ff, credit_in;
   logic [NSTEP:0]              vld_ff, vld_in;
   logic [NS-1:0][DW-1:0]       x_ff [NSTEP+1];
   logic [NS-1:0][DW-1:0]       x_in [NSTEP+1];
   logic [NS-1:0][SW-1:0]       r_ff [NSTEP+1];
   logic [NS-1:0][SW-1:0]       r_in [NSTEP+1];
   logic [SW-1:0]               span_ff [NSTEP+1];
   logic                        oor_ff [NSTEP+1];
   logic                        out_vld_ff;
   antp_pkg::rsp_type           out_ff, out_in;

   // outstanding count covers the pipe and the output FIFO
   assign in_take  = in_avail && (credit_ff != CW'(OUT_DEPTH));
   assign out_vld  = out_vld_ff;
   assign out_data = out_ff;

   always_comb begin
      credit_in = credit_ff + CW'(in_take) - CW'(out_pop);
      vld_in    = {vld_ff[NSTEP-1:0], in_take};
   end

   // entry: signed combine, add half divisor, drop the extra fraction bits
   always_comb begin
      logic [antp_pkg::PROD_W-1:0] n;
      logic [HW-1:0]               half;
      logic [DW-1:0]               sum;
      half = HW'(({{(HW-SW){1'b0}}, in_data.span} << K) >> 1);
      x_in[0] = '0;
      r_in[0] = '0;
      for (int s = 0; s < NS; s++) begin
         n = in_data.dec[s] ? in_data.p1[s] - in_data.p2[s]
                            : in_data.p1[s] + in_data.p2[s];
         sum = {1'b0, n} + DW'(half);
         x_in[0][s] = sum >> K;
      end
   end

   // two quotient bits per stage, restoring
   for (genvar g = 0; g < NSTEP; g++) begin : g_div
      always_comb begin
         logic [DW-1:0] xv;
         logic [SW:0]   t;
         logic          ge;
         for (int s = 0; s < NS; s++) begin
            xv = x_ff[g][s];
            t  = {1'b0, r_ff[g][s]};
            for (int b = 0; b < 2; b++) begin
               t  = {t[SW-1:0], xv[DW-1]};
               ge = (t >= {1'b0, span_ff[g]});
               if (ge) begin
                  t = t - {1'b0, span_ff[g]};
               end
               xv = {xv[DW-2:0], ge};
            end
            x_in[g+1][s] = xv;
            r_in[g+1][s] = t[SW-1:0];
         end
      end

      always_ff @(posedge clock) begin
         x_ff[g+1]    <= x_in[g+1];
         r_ff[g+1]    <= r_in[g+1];
         span_ff[g+1] <= span_ff[g];
         oor_ff[g+1]  <= oor_ff[g];
      end
   end

   always_comb begin
      logic [antp_pkg::SUM_W-1:0] acc;
      acc = antp_pkg::SUM_W'(base_temp);
      for (int s = 0; s < NS; s++) begin
         acc = acc + antp_pkg::SUM_W'(x_ff[NSTEP][s]);
      end
      out_in.total_temp   = (acc > antp_pkg::SUM_W'(antp_pkg::TOTAL_MAX))
                            ? antp_pkg::TOTAL_MAX : acc[antp_pkg::TOT_W-1:0];
      out_in.out_of_range = oor_ff[NSTEP];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff  <= '0;
         vld_ff     <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         credit_ff  <= credit_in;
         vld_ff     <= vld_in;
         out_vld_ff <= vld_ff[NSTEP];
      end
   end

   always_ff @(posedge clock) begin
      x_ff[0]    <= x_in[0];
      r_ff[0]    <= r_in[0];
      span_ff[0] <= in_data.span;
      oor_ff[0]  <= in_data.oor;
      out_ff     <= out_in;
   end

endmodule

FILE: hw/rtl/antp_checker.sv
// ----------------------------------------------------------------------------
// antp_checker
// Port-level checks for the antenna noise temperature block.
// ----------------------------------------------------------------------------
module antp_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_full,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input antp_pkg::rsp_type rsp_data
);

   // pipeline is deep: nothing can come out right after reset
   a_empty_after_reset : assert property (@(posedge clock)
      $past(reset) |-> rsp_empty)
      else $error("result visible right after reset");

   a_ready_after_reset : assert property (@(posedge clock)
      $past(reset) |-> !req_full)
      else $error("front not ready after reset");

   a_hold_valid : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> !rsp_empty)
      else $error("result withdrawn without pop");

   a_hold_data : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> $stable(rsp_data))
      else $error("stalled result changed");

endmodule

bind antenna_noise_temp_interp antp_checker u_antp_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);
